// File: rtl/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types, codes and constants of the led strip effect sequencer.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int MAX_PIXELS = 1024;

    // the strip never runs longer than the 10-bit pixel index can address
    localparam logic [10:0] STRIP_LIMIT = 11'((MAX_PIXELS > 1024) ? 1024 : MAX_PIXELS);

    localparam logic [9:0]  RAMP_FLOOR = 10'd5;
    localparam logic [9:0]  STEP_MAX   = 10'h3FF;
    localparam logic [15:0] TICK_MAX   = 16'hFFFF;

    // register indexes on the configuration port
    localparam logic [2:0] REG_POWER_ON        = 3'd0;
    localparam logic [2:0] REG_EFFECT_MODE     = 3'd1;
    localparam logic [2:0] REG_FX_COLOR        = 3'd2;
    localparam logic [2:0] REG_STEP_PERIOD     = 3'd3;
    localparam logic [2:0] REG_LIGHT_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_BRIGHTNESS      = 3'd5;
    localparam logic [2:0] REG_PIXEL_COUNT     = 3'd6;

    // effect modes
    localparam logic [1:0] MODE_STILL     = 2'd0;
    localparam logic [1:0] MODE_BREATHING = 2'd1;
    localparam logic [1:0] MODE_CIRCLING  = 2'd2;

    // strip commands
    localparam logic [2:0] ACT_NONE       = 3'd0;
    localparam logic [2:0] ACT_CLEAR      = 3'd1;
    localparam logic [2:0] ACT_SHOW       = 3'd2;
    localparam logic [2:0] ACT_FILL       = 3'd3;
    localparam logic [2:0] ACT_SET_PIXEL  = 3'd4;

    typedef struct packed {
        logic        power_on;
        logic [1:0]  effect_mode;
        logic [31:0] fx_color;
        logic [7:0]  step_period;
        logic [11:0] light_threshold;
        logic [7:0]  brightness;
        logic [10:0] pixel_count;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  level;
        logic [31:0] pixel_color;
        logic [9:0]  pixel_index;
    } result_t;

endpackage

// File: rtl/lss_cfg_regs.sv
// ----------------------------------------------------------------------------
// lss_cfg_regs
// Configuration register file, written through the cfg channel.
// ----------------------------------------------------------------------------
module lss_cfg_regs
    import lss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [31:0] wr_data,
    output cfg_t        cfg,
    output logic        mode_wr
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        mode_wr  = 1'b0;
        if (wr_en) begin
            unique case (wr_index)
                REG_POWER_ON:        cfg_next.power_on        = wr_data[0];
                REG_EFFECT_MODE: begin
                    cfg_next.effect_mode = wr_data[1:0];
                    mode_wr              = 1'b1;
                end
                REG_FX_COLOR:        cfg_next.fx_color        = wr_data;
                REG_STEP_PERIOD:     cfg_next.step_period     = wr_data[7:0];
                REG_LIGHT_THRESHOLD: cfg_next.light_threshold = wr_data[11:0];
                REG_BRIGHTNESS:      cfg_next.brightness      = wr_data[7:0];
                REG_PIXEL_COUNT:     cfg_next.pixel_count     = wr_data[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.power_on        <= 1'b0;
            cfg_reg.effect_mode     <= MODE_STILL;
            cfg_reg.fx_color        <= 32'd0;
            cfg_reg.step_period     <= 8'd200;
            cfg_reg.light_threshold <= 12'd0;
            cfg_reg.brightness      <= 8'd50;
            cfg_reg.pixel_count     <= 11'd60;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/lss_effect_core.sv
// ----------------------------------------------------------------------------
// lss_effect_core
// Effect state and the per-tick command decision.
// ----------------------------------------------------------------------------
module lss_effect_core
    import lss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        mode_wr,
    input  logic        tick,
    input  logic [11:0] ambient,
    output result_t     result
);

    logic        lit_reg, lit_next;
    logic [9:0]  step_reg, step_next;
    logic        falling_reg, falling_next;
    logic [15:0] ticks_reg, ticks_next;

    logic [15:0] ticks_inc;
    logic        due;
    logic        above;
    logic [10:0] strip_len;
    logic [9:0]  circ_pos;

    always_comb begin
        ticks_inc = (ticks_reg < TICK_MAX) ? ticks_reg + 16'd1 : ticks_reg;
        due       = ticks_inc > {8'd0, cfg.step_period};
        above     = ambient > cfg.light_threshold;

        if (cfg.pixel_count == 11'd0) begin
            strip_len = 11'd1;
        end else if (cfg.pixel_count > STRIP_LIMIT) begin
            strip_len = STRIP_LIMIT;
        end else begin
            strip_len = cfg.pixel_count;
        end
        circ_pos = ({1'b0, step_reg} >= strip_len) ? 10'd0 : step_reg;
    end

    always_comb begin
        lit_next     = lit_reg;
        step_next    = step_reg;
        falling_next = falling_reg;
        ticks_next   = ticks_reg;
        result       = '0;

        if (tick) begin
            ticks_next = ticks_inc;
            if (!cfg.power_on) begin
                result.action = ACT_CLEAR;
            end else if (!above && lit_reg) begin
                lit_next      = 1'b0;
                result.action = ACT_CLEAR;
            end else if (above || lit_reg) begin
                lit_next = 1'b1;
                case (cfg.effect_mode)
                    MODE_BREATHING: begin
                        if (due) begin
                            if (!falling_reg && step_reg >= {2'd0, cfg.brightness}) begin
                                falling_next = 1'b1;
                            end else if (falling_reg && step_reg < RAMP_FLOOR) begin
                                falling_next = 1'b0;
                            end
                            result.action      = ACT_FILL;
                            result.level       = (step_reg > 10'd255) ? 8'd255 : step_reg[7:0];
                            result.pixel_color = cfg.fx_color;
                            if (!falling_next) begin
                                if (step_reg < STEP_MAX) step_next = step_reg + 10'd1;
                            end else if (step_reg != 10'd0) begin
                                step_next = step_reg - 10'd1;
                            end
                            ticks_next = 16'd0;
                        end
                    end
                    MODE_CIRCLING: begin
                        if (due) begin
                            result.action      = ACT_SET_PIXEL;
                            result.level       = cfg.brightness;
                            result.pixel_color = cfg.fx_color;
                            result.pixel_index = circ_pos;
                            step_next          = circ_pos + 10'd1;
                            ticks_next         = 16'd0;
                        end
                    end
                    default: begin
                        // still mode, unused mode code behaves the same
                        result.action = ACT_SHOW;
                        result.level  = cfg.brightness;
                    end
                endcase
            end
        end

        // mode writes must come only while idle so they never meet a tick; the block does not enforce this
        if (mode_wr) begin
            step_next    = 10'd0;
            falling_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lit_reg     <= 1'b0;
            step_reg    <= 10'd0;
            falling_reg <= 1'b0;
            ticks_reg   <= 16'd0;
        end else begin
            lit_reg     <= lit_next;
            step_reg    <= step_next;
            falling_reg <= falling_next;
            ticks_reg   <= ticks_next;
        end
    end

endmodule

// File: rtl/led_strip_effect_sequencer.sv
// ----------------------------------------------------------------------------
// led_strip_effect_sequencer
// One strip command per millisecond light sample: none, clear, show, breathing
// fill or circling pixel, following power, darkness threshold and effect mode.
// ----------------------------------------------------------------------------
// datapath: an accepted input item is held in the input register, and its result
// is loaded into the result register when it fires; a stall on m_ready holds both
// throughput: one item per cycle unless m_ready stalls the output; the effect state
// updates on the edge that loads the result register from the input register
// reset: synchronous active-low aresetn clears both pipeline stages and the
// effect state and loads the register defaults; no clearing pass
module led_strip_effect_sequencer
    import lss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [11:0] s_ambient,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_action,
    output logic [7:0]  m_level,
    output logic [31:0] m_pixel_color,
    output logic [9:0]  m_pixel_index,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t        cfg;
    logic        mode_wr;
    result_t     result;

    logic        in_valid_reg;
    logic [11:0] in_level_reg;
    logic        out_valid_reg;
    result_t     out_reg;

    logic        stall;
    logic        fire;

    assign stall     = out_valid_reg && !m_ready;
    assign fire      = in_valid_reg && !stall;
    assign s_ready   = !in_valid_reg || !stall;
    assign cfg_ready = 1'b1;

    lss_cfg_regs u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg),
        .mode_wr  (mode_wr)
    );

    lss_effect_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .mode_wr     (mode_wr),
        .tick        (fire),
        .ambient     (in_level_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (!stall) out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_level_reg <= s_ambient;
        if (fire) out_reg <= result;
    end

    assign m_valid       = out_valid_reg;
    assign m_action      = out_reg.action;
    assign m_level       = out_reg.level;
    assign m_pixel_color = out_reg.pixel_color;
    assign m_pixel_index = out_reg.pixel_index;

endmodule
